FILE: hdl/pcb_pkg.sv
// Shared types and codes of the pretrigger capture buffer.
package pcb_pkg;

	// Request opcodes
	localparam logic [1:0] OP_SAMPLE  = 2'd0;
	localparam logic [1:0] OP_ARM     = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_RELEASE = 2'd3;

	// Capture phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_REC  = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	// Trigger modes
	localparam logic [1:0] TM_AUTO    = 2'd0;
	localparam logic [1:0] TM_RISING  = 2'd1;
	localparam logic [1:0] TM_FALLING = 2'd2;
	localparam logic [1:0] TM_FLAG    = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_TRIGGER_LEVEL    = 2'd0;
	localparam logic [1:0] CFG_TRIGGER_MODE     = 2'd1;
	localparam logic [1:0] CFG_CONTINUOUS_MODE  = 2'd2;
	localparam logic [1:0] CFG_PRETRIGGER_COUNT = 2'd3;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic       wr;
		logic       rd;
		logic [1:0] chan;
		logic [1:0] phase;
	} cmd_ctrl_t;

endpackage

FILE: hdl/pretrigger_capture_buffer_core.sv
// Top level of the pretrigger capture buffer: front, command queue and back part.
//
// The block records CHANNELS sample channels into a circular memory of DEPTH rows.
// Requests arrive on the input channel (in_valid / in_stall) and each accepted request
// yields exactly one result on the output channel (out_valid / out_stall), in order.
// A sample tick writes all channels at the write position and, while waiting, tests
// the trigger; arm, read and release requests drive the capture phase, and a read
// returns the stored sample at the given position counted from the oldest entry.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user must
// write it only while no request is in flight, as the block itself does not enforce this.
// The front part updates the capture state in the cycle a request is accepted and
// places a command in a four-entry queue; the back part performs the single memory
// access and holds the result in its output register. A command thus passes the
// queue and then the output register before its result is offered, and one request
// per cycle is sustained while the receiver does not stall, set by the single
// write-or-read port of the capture memory.
// Reset clears the phase, positions, trigger history, queue and output valid, and
// loads the configuration defaults; the memory itself is not cleared, so reading a
// row that was never written returns undefined data.
// When the receiver stalls, the result is held, the queue fills, and in_stall rises
// once the queue is full; nothing is lost or repeated.
module pretrigger_capture_buffer_core
	import pcb_pkg::*;
#(
	parameter int DEPTH       = 256,
	parameter int CHANNELS    = 4,
	parameter int SAMPLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic signed [15:0] sample_ch0,
	input  logic signed [15:0] sample_ch1,
	input  logic signed [15:0] sample_ch2,
	input  logic signed [15:0] sample_ch3,
	input  logic signed [15:0] trigger_value,
	input  logic               error_flag,
	input  logic [7:0]         read_position,
	input  logic [1:0]         read_channel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] read_sample,
	output logic [1:0]         capture_state
);

	localparam int AW = $clog2(DEPTH);
	localparam int DW = CHANNELS * SAMPLE_BITS;
	localparam int CW = $bits(cmd_ctrl_t);
	localparam int QW = CW + AW + DW;

	logic            q_full, q_empty, push, pop;
	cmd_ctrl_t       push_ctrl;
	logic [AW-1:0]   push_addr;
	logic [DW-1:0]   push_data;
	logic [QW-1:0]   q_in, q_out;

	// The front commits the phase change at acceptance, so later requests see it at once.
	pcb_front #(
		.DEPTH       (DEPTH),
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.AW          (AW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.sample_ch0    (sample_ch0),
		.sample_ch1    (sample_ch1),
		.sample_ch2    (sample_ch2),
		.sample_ch3    (sample_ch3),
		.trigger_value (trigger_value),
		.error_flag    (error_flag),
		.read_position (read_position),
		.read_channel  (read_channel),
		.q_full        (q_full),
		.push          (push),
		.push_ctrl     (push_ctrl),
		.push_addr     (push_addr),
		.push_data     (push_data)
	);

	assign q_in = {push_ctrl, push_addr, push_data};

	// Memory commands stay in request order, so a read always follows earlier writes.
	pcb_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	pcb_back #(
		.DEPTH       (DEPTH),
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.AW          (AW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (q_empty),
		.pop           (pop),
		.pop_ctrl      (cmd_ctrl_t'(q_out[QW-1 -: CW])),
		.pop_addr      (q_out[DW +: AW]),
		.pop_data      (q_out[DW-1:0]),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_sample   (read_sample),
		.capture_state (capture_state)
	);

endmodule

FILE: hdl/pcb_front.sv
// Front part: takes requests, keeps the capture control state and issues memory commands.
module pcb_front
	import pcb_pkg::*;
#(
	parameter int DEPTH       = 256,
	parameter int CHANNELS    = 4,
	parameter int SAMPLE_BITS = 16,
	parameter int AW          = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [1:0]                      cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      opcode,
	input  logic signed [15:0]              sample_ch0,
	input  logic signed [15:0]              sample_ch1,
	input  logic signed [15:0]              sample_ch2,
	input  logic signed [15:0]              sample_ch3,
	input  logic signed [15:0]              trigger_value,
	input  logic                            error_flag,
	input  logic [7:0]                      read_position,
	input  logic [1:0]                      read_channel,
	input  logic                            q_full,
	output logic                            push,
	output cmd_ctrl_t                       push_ctrl,
	output logic [AW-1:0]                   push_addr,
	output logic [CHANNELS*SAMPLE_BITS-1:0] push_data
);

	localparam int SW = ((AW > 8) ? AW : 8) + 2;

	// Reduces an 8-bit value modulo DEPTH by restoring subtraction, eight steps.
	function automatic logic [7:0] mod_depth(input logic [7:0] v);
		logic [31:0] r;
		r = {24'd0, v};
		for (int j = 7; j >= 0; j--) begin
			if (r >= (32'(DEPTH) << j))
				r = r - (32'(DEPTH) << j);
		end
		return r[7:0];
	endfunction

	logic signed [15:0] level_q;
	logic [1:0]         mode_q;
	logic               cont_q;
	logic [7:0]         pre_q;

	logic [1:0]         phase_q, phase_n;
	logic [AW-1:0]      wp_q, wp_n;
	logic [AW-1:0]      end_q, end_n;
	logic signed [15:0] prev_q, prev_n;

	logic               accept;
	logic               fire;
	logic [SW-1:0]      wp_x, pre_x, end_x, rsum;
	logic [AW-1:0]      wp_inc;
	logic signed [15:0] samp [4];
	logic signed [31:0] ext [4];

	assign accept   = in_valid && !in_stall;
	assign in_stall = q_full;

	assign samp[0] = sample_ch0;
	assign samp[1] = sample_ch1;
	assign samp[2] = sample_ch2;
	assign samp[3] = sample_ch3;

	always_comb begin
		for (int c = 0; c < 4; c++)
			ext[c] = 32'(samp[c]);
		for (int c = 0; c < CHANNELS; c++)
			push_data[c*SAMPLE_BITS +: SAMPLE_BITS] = ext[c][SAMPLE_BITS-1:0];
	end

	// End position while waiting: write position minus pretrigger, wrapped.
	always_comb begin
		wp_x  = SW'(wp_q);
		pre_x = SW'(pre_q);
		if (wp_x >= pre_x)
			end_x = wp_x - pre_x;
		else
			end_x = wp_x + SW'(DEPTH) - pre_x;
	end

	// Read address: end position + 1 + ordered index, wrapped.
	always_comb begin
		rsum = SW'(end_q) + SW'(1) + SW'(mod_depth(read_position));
		if (rsum >= SW'(DEPTH))
			rsum = rsum - SW'(DEPTH);
	end

	assign wp_inc = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;

	always_comb begin
		unique case (mode_q)
			TM_AUTO:    fire = 1'b1;
			TM_RISING:  fire = (level_q < trigger_value) && (level_q > prev_q);
			TM_FALLING: fire = (level_q > trigger_value) && (level_q < prev_q);
			TM_FLAG:    fire = error_flag;
			default:    fire = 1'b0;
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		wp_n    = wp_q;
		end_n   = end_q;
		prev_n  = prev_q;
		unique case (opcode)
			OP_SAMPLE: begin
				if (phase_q == PH_REC && end_q == wp_q)
					phase_n = PH_DONE;
				if (phase_q == PH_WAIT) begin
					if (fire)
						phase_n = PH_REC;
					prev_n = trigger_value;
					end_n  = end_x[AW-1:0];
				end
				if (phase_n != PH_DONE)
					wp_n = wp_inc;
			end
			OP_ARM: begin
				if (phase_q == PH_IDLE)
					phase_n = PH_WAIT;
			end
			OP_RELEASE: begin
				if (phase_q == PH_DONE)
					phase_n = cont_q ? PH_WAIT : PH_IDLE;
			end
			default: ;
		endcase
	end

	assign push           = accept;
	assign push_ctrl.wr   = (opcode == OP_SAMPLE);
	assign push_ctrl.rd   = (opcode == OP_READ);
	assign push_ctrl.chan = read_channel;
	assign push_ctrl.phase = phase_n;
	assign push_addr      = (opcode == OP_READ) ? rsum[AW-1:0] : wp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			mode_q  <= TM_RISING;
			cont_q  <= 1'b0;
			pre_q   <= mod_depth(8'd128);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_TRIGGER_LEVEL:    level_q <= cfg_data;
				CFG_TRIGGER_MODE:     mode_q  <= cfg_data[1:0];
				CFG_CONTINUOUS_MODE:  cont_q  <= cfg_data[0];
				CFG_PRETRIGGER_COUNT: pre_q   <= mod_depth(cfg_data[7:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wp_q    <= '0;
			end_q   <= '0;
			prev_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			wp_q    <= wp_n;
			end_q   <= end_n;
			prev_q  <= prev_n;
		end
	end

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wp_q) < DEPTH) else $error("write position out of range");

	a_end_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(end_q) < DEPTH) else $error("end position out of range");

	a_done_holds_wp: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE && accept) |=> $stable(wp_q))
		else $error("write position moved after capture finished");

endmodule

FILE: hdl/pcb_queue.sv
// Short command queue between the front and the back part.
module pcb_queue
	import pcb_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0]  slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into a full command queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("pop from an empty command queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

FILE: hdl/pcb_back.sv
// Back part: capture memory and the result output register.
module pcb_back
	import pcb_pkg::*;
#(
	parameter int DEPTH       = 256,
	parameter int CHANNELS    = 4,
	parameter int SAMPLE_BITS = 16,
	parameter int AW          = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            empty,
	output logic                            pop,
	input  cmd_ctrl_t                       pop_ctrl,
	input  logic [AW-1:0]                   pop_addr,
	input  logic [CHANNELS*SAMPLE_BITS-1:0] pop_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [15:0]              read_sample,
	output logic [1:0]                      capture_state
);

	logic [CHANNELS*SAMPLE_BITS-1:0] mem [DEPTH];
	logic [CHANNELS*SAMPLE_BITS-1:0] row_s1;
	cmd_ctrl_t                       ctrl_s1;
	logic                            valid_s1;
	logic                            advance;
	logic signed [SAMPLE_BITS-1:0]   sel;
	logic signed [31:0]              sel_ext;
	logic                            hit;

	assign advance = !valid_s1 || !out_stall;
	assign pop     = advance && !empty;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (pop_ctrl.wr)
				mem[pop_addr] <= pop_data;
			row_s1  <= mem[pop_addr];
			ctrl_s1 <= pop_ctrl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= !empty;
	end

	always_comb begin
		sel = '0;
		hit = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (32'(ctrl_s1.chan) == c) begin
				sel = row_s1[c*SAMPLE_BITS +: SAMPLE_BITS];
				hit = 1'b1;
			end
		end
		sel_ext = 32'(sel);
	end

	assign out_valid     = valid_s1;
	assign read_sample   = (ctrl_s1.rd && hit) ? sel_ext[15:0] : 16'sd0;
	assign capture_state = ctrl_s1.phase;

	a_pop_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_stall) |-> !pop) else $error("command popped while result stalled");

endmodule

FILE: bench/tb_pretrigger_capture_buffer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pretrigger capture buffer core with an in-order result predictor.
module tb_pretrigger_capture_buffer_core;
	import pcb_pkg::*;

	// The memory has 256 rows, so 8-bit position arithmetic wraps exactly as the block does.
	localparam int ROW_COUNT       = 256;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int REQUEST_TARGET  = 1650;
	localparam int ROUND_MAX_ITEMS = 450;
	localparam int ROUND_MAX_WAITS = 80;
	localparam int PRESSURE_AFTER  = 300;
	localparam int PRESSURE_CYCLES = 80;
	localparam int DRAIN_CYCLES    = 8;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [3:0][15:0] channel;
		logic [15:0]      trigger_value;
		logic             error_flag;
		logic [7:0]       read_position;
		logic [1:0]       read_channel;
	} capture_request_t;

	typedef struct packed {
		logic [15:0] sample;
		logic [1:0]  state;
	} capture_result_t;

	// The tracker mirrors the capture state and configuration of the block. It
	// works out the result of every accepted request and keeps the expected
	// results in order until the output channel delivers them.
	class capture_tracker;
		logic [15:0] level;
		logic [1:0]  mode;
		logic        rearm;
		logic [7:0]  pretrigger;
		logic [1:0]  phase;
		logic [7:0]  write_pos;
		logic [7:0]  end_pos;
		logic [15:0] last_trigger;
		logic [15:0] rows [ROW_COUNT][4];
		bit          row_written [ROW_COUNT];
		int          rows_in_use;
		int          failures;
		capture_result_t pending_results [$];

		function void clear();
			level        = '0;
			mode         = TM_RISING;
			rearm        = 1'b0;
			pretrigger   = 8'd128;
			phase        = PH_IDLE;
			write_pos    = '0;
			end_pos      = '0;
			last_trigger = '0;
			foreach (row_written[i])
				row_written[i] = 1'b0;
			rows_in_use = 0;
			failures    = 0;
			pending_results.delete();
		endfunction

		function void write_register(logic [1:0] index, logic [15:0] data);
			case (index)
				CFG_TRIGGER_LEVEL:    level = data;
				CFG_TRIGGER_MODE:     mode = data[1:0];
				CFG_CONTINUOUS_MODE:  rearm = data[0];
				CFG_PRETRIGGER_COUNT: pretrigger = data[7:0];
				default: ;
			endcase
		endfunction

		function void predict_request(capture_request_t req);
			capture_result_t res;
			logic            fire;
			logic [7:0]      row;
			res.sample = '0;
			fire = 1'b0;
			case (req.opcode)
				OP_SAMPLE: begin
					for (int c = 0; c < 4; c++)
						rows[write_pos][c] = req.channel[c];
					if (!row_written[write_pos]) begin
						row_written[write_pos] = 1'b1;
						rows_in_use++;
					end
					if (phase == PH_REC && end_pos == write_pos)
						phase = PH_DONE;
					if (phase == PH_WAIT) begin
						case (mode)
							TM_AUTO: fire = 1'b1;
							TM_RISING: fire = ($signed(level) < $signed(req.trigger_value)) &&
								($signed(level) > $signed(last_trigger));
							TM_FALLING: fire = ($signed(level) > $signed(req.trigger_value)) &&
								($signed(level) < $signed(last_trigger));
							default: fire = req.error_flag;
						endcase
						if (fire)
							phase = PH_REC;
						last_trigger = req.trigger_value;
						end_pos = write_pos - pretrigger;
					end
					if (phase != PH_DONE)
						write_pos = write_pos + 8'd1;
				end
				OP_ARM: begin
					if (phase == PH_IDLE)
						phase = PH_WAIT;
				end
				OP_READ: begin
					row = end_pos + 8'd1 + req.read_position;
					res.sample = rows[row][req.read_channel];
				end
				default: begin
					if (phase == PH_DONE)
						phase = rearm ? PH_WAIT : PH_IDLE;
				end
			endcase
			res.state = phase;
			pending_results.push_back(res);
		endfunction

		// Ordered index that addresses a given memory row under the current end position.
		function logic [7:0] position_of(logic [7:0] row);
			return row - end_pos - 8'd1;
		endfunction

		// A random ordered index whose row has been written; callers make sure one exists.
		function logic [7:0] pick_read_position();
			logic [7:0] row;
			row = end_pos + 8'd1 + 8'($urandom_range(0, 255));
			while (!row_written[row])
				row = row + 8'd1;
			return position_of(row);
		endfunction

		function void check_result(logic [15:0] sample, logic [1:0] state);
			capture_result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result: read_sample %0d capture_state %0d",
					$signed(sample), state);
				failures++;
				return;
			end
			want = pending_results.pop_front();
			if (sample !== want.sample) begin
				$error("read_sample expected %0d got %0d", $signed(want.sample), $signed(sample));
				failures++;
			end
			if (state !== want.state) begin
				$error("capture_state expected %0d got %0d", want.state, state);
				failures++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         opcode;
	logic signed [15:0] sample_ch0;
	logic signed [15:0] sample_ch1;
	logic signed [15:0] sample_ch2;
	logic signed [15:0] sample_ch3;
	logic signed [15:0] trigger_value;
	logic               error_flag;
	logic [7:0]         read_position;
	logic [1:0]         read_channel;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] read_sample;
	logic [1:0]         capture_state;

	capture_tracker tracker;
	int requests_sent = 0;
	int cycle_count = 0;

	pretrigger_capture_buffer_core DUT (.*);

	// A 20 ns clock: low for the first half of each period, then high.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog: a hung handshake or a lost result ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pretrigger_capture_buffer_core verification failed");
			$finish;
		end
	end

	// Every result that the output channel hands over is compared with the oldest
	// expectation. Sampling happens at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			tracker.check_result(read_sample, capture_state);
	end

	// Result receiver. For each result it draws a random number of stall cycles,
	// except in every fourth block of fifty results where it takes results at full
	// rate. Once, after a few hundred results, it holds off for a long stretch so
	// that the internal queue fills and the block raises in_stall against the sender.
	initial begin
		int  wait_cycles;
		int  taken;
		bit  held;
		taken = 0;
		held = 1'b0;
		out_stall = 1'b1;
		forever begin
			if (!held && taken >= PRESSURE_AFTER) begin
				held = 1'b1;
				out_stall = 1'b1;
				repeat (PRESSURE_CYCLES) @(negedge clk);
			end
			wait_cycles = ((taken / 50) % 4 == 1) ? 0 : int'($urandom_range(0, 9));
			if (wait_cycles > 0) begin
				out_stall = 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall = 1'b0;
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
			taken++;
			@(negedge clk);
		end
	end

	// Offers one request and holds it until the block takes it. The tracker learns
	// of the request at the accepting edge, so the next request is always drawn from
	// the up-to-date capture state. The sender then idles for a random gap, except in
	// every fourth block of 64 requests where requests follow back to back.
	task automatic drive_request(input capture_request_t req);
		int gap;
		opcode        = req.opcode;
		sample_ch0    = req.channel[0];
		sample_ch1    = req.channel[1];
		sample_ch2    = req.channel[2];
		sample_ch3    = req.channel[3];
		trigger_value = req.trigger_value;
		error_flag    = req.error_flag;
		read_position = req.read_position;
		read_channel  = req.read_channel;
		in_valid      = 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		tracker.predict_request(req);
		requests_sent++;
		@(negedge clk);
		gap = ((requests_sent / 64) % 4 == 3) ? 0 : int'($urandom_range(0, 9));
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// A request with every field random; callers then shape the fields that matter.
	function automatic capture_request_t random_request();
		capture_request_t req;
		req.opcode = 2'($urandom_range(0, 3));
		for (int c = 0; c < 4; c++)
			req.channel[c] = 16'($urandom);
		req.trigger_value = 16'($urandom);
		req.error_flag    = ($urandom_range(0, 7) == 0);
		req.read_position = 8'($urandom_range(0, 255));
		req.read_channel  = 2'($urandom_range(0, 3));
		return req;
	endfunction

	function automatic capture_request_t sample_request(logic [15:0] c0, logic [15:0] c1,
			logic [15:0] c2, logic [15:0] c3, logic [15:0] trig, logic err);
		capture_request_t req;
		req = random_request();
		req.opcode        = OP_SAMPLE;
		req.channel       = {c3, c2, c1, c0};
		req.trigger_value = trig;
		req.error_flag    = err;
		return req;
	endfunction

	function automatic capture_request_t control_request(logic [1:0] op);
		capture_request_t req;
		req = random_request();
		req.opcode = op;
		return req;
	endfunction

	// Reads a row that is known to hold data, addressed by its ordered index.
	function automatic capture_request_t read_request(logic [7:0] row, logic [1:0] chan);
		capture_request_t req;
		req = random_request();
		req.opcode        = OP_READ;
		req.read_position = tracker.position_of(row);
		req.read_channel  = chan;
		return req;
	endfunction

	// Trigger values that are random or sit on, just above or just below the level, so
	// that the strict crossing tests of the level modes are hit from both sides.
	function automatic logic [15:0] trigger_near_level();
		int lvl;
		lvl = int'($signed(tracker.level));
		case ($urandom_range(0, 3))
			0: lvl = int'($urandom);
			1: lvl = (lvl < 32767) ? lvl + 1 : lvl;
			2: lvl = (lvl > -32768) ? lvl - 1 : lvl;
			default: ;
		endcase
		return lvl[15:0];
	endfunction

	task automatic write_register(input logic [1:0] index, input logic [15:0] data);
		cfg_write = 1'b1;
		cfg_index = index;
		cfg_data  = data;
		@(negedge clk);
		tracker.write_register(index, data);
	endtask

	// Registers are only written once every outstanding result has come back. The
	// first setups pin the extremes; later ones are random, with the pretrigger
	// count kept mostly high so that a capture finishes in fewer sample ticks.
	// Unused upper bits of the write data are random, as the block ignores them.
	task automatic configure(input int setup);
		logic [15:0] lvl;
		logic [1:0]  tmode;
		logic        cont;
		logic [7:0]  pre;
		in_valid = 1'b0;
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		case (setup)
			0: begin lvl = 16'h8000; tmode = TM_AUTO;    cont = 1'b1; pre = 8'd255; end
			1: begin lvl = 16'($urandom); tmode = TM_FALLING; cont = 1'b0; pre = 8'd0; end
			2: begin lvl = 16'h7FFF; tmode = TM_RISING;  cont = 1'b0; pre = 8'd1;   end
			3: begin lvl = 16'($urandom); tmode = TM_FLAG; cont = 1'b1; pre = 8'd200; end
			4: begin lvl = 16'h0000; tmode = TM_RISING;  cont = 1'b0; pre = 8'd128; end
			default: begin
				case ($urandom_range(0, 5))
					0: lvl = 16'h8000;
					1: lvl = 16'h7FFF;
					default: lvl = 16'($urandom);
				endcase
				tmode = 2'($urandom_range(0, 3));
				cont  = 1'($urandom_range(0, 1));
				pre   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(160, 255));
			end
		endcase
		write_register(CFG_TRIGGER_LEVEL, lvl);
		write_register(CFG_TRIGGER_MODE, {14'($urandom), tmode});
		write_register(CFG_CONTINUOUS_MODE, {15'($urandom), cont});
		write_register(CFG_PRETRIGGER_COUNT, {8'($urandom), pre});
		cfg_write = 1'b0;
	endtask

	// One capture round: most requests follow the normal flow of arm, sample ticks
	// until the capture is done, a few reads and a release; the rest are random
	// requests that hit ignored arms and releases and reads in other phases. A round
	// also ends when a trigger fails to come, the round runs long or enough requests
	// have been sent.
	task automatic capture_round(input int setup);
		capture_request_t req;
		int round_items;
		int wait_samples;
		int reads_left;
		bit released;
		configure(setup);
		round_items  = 0;
		wait_samples = 0;
		reads_left   = $urandom_range(2, 12);
		released     = 1'b0;
		while (!released && round_items < ROUND_MAX_ITEMS && wait_samples < ROUND_MAX_WAITS
				&& requests_sent < REQUEST_TARGET) begin
			req = random_request();
			if ($urandom_range(0, 99) < 85) begin
				case (tracker.phase)
					PH_IDLE: req.opcode = OP_ARM;
					PH_WAIT: begin
						req.opcode = OP_SAMPLE;
						req.trigger_value = trigger_near_level();
						wait_samples++;
					end
					PH_REC: req.opcode = OP_SAMPLE;
					default: begin
						if (reads_left > 0) begin
							req.opcode = OP_READ;
							reads_left--;
						end else begin
							req.opcode = OP_RELEASE;
						end
					end
				endcase
			end
			// Rows that were never written hold undefined data, so reads only go
			// to rows that a sample tick has filled.
			if (req.opcode == OP_READ) begin
				if (tracker.rows_in_use == 0)
					req.opcode = OP_SAMPLE;
				else
					req.read_position = tracker.pick_read_position();
			end
			if (req.opcode == OP_RELEASE && tracker.phase == PH_DONE)
				released = 1'b1;
			drive_request(req);
			round_items++;
		end
	endtask

	initial begin
		int setup;
		tracker = new;
		tracker.clear();
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = CFG_TRIGGER_LEVEL;
		cfg_data      = '0;
		in_valid      = 1'b0;
		opcode        = OP_SAMPLE;
		sample_ch0    = '0;
		sample_ch1    = '0;
		sample_ch2    = '0;
		sample_ch3    = '0;
		trigger_value = '0;
		error_flag    = 1'b0;
		read_position = '0;
		read_channel  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed opening under the reset configuration (level 0, rising mode,
		// single capture, pretrigger 128). A release while idle is ignored, and a
		// sample tick while idle still writes row 0 with the extreme sample values.
		drive_request(control_request(OP_RELEASE));
		drive_request(sample_request(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h8000, 1'b1));
		// Row 0 with end position 0 is the ordered index 255.
		drive_request(read_request(8'd0, 2'd1));
		// The second arm arrives while already waiting and must be ignored.
		drive_request(control_request(OP_ARM));
		drive_request(control_request(OP_ARM));
		drive_request(sample_request(16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'hFFFB, 1'b1));
		// A value equal to the level does not fire, nor does a previous value equal
		// to it; the crossing from -1 to 1 then fires the rising trigger.
		drive_request(sample_request(16'h0001, 16'hFFFE, 16'h4000, 16'hC000, 16'h0000, 1'b0));
		drive_request(sample_request(16'h1234, 16'hEDCB, 16'h7FFE, 16'h8001, 16'h0005, 1'b0));
		drive_request(sample_request(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'hFFFF, 1'b0));
		drive_request(sample_request(16'h2AAA, 16'hD555, 16'h3333, 16'hCCCC, 16'h0001, 1'b0));
		drive_request(read_request(tracker.write_pos - 8'd1, 2'd3));
		// A release while recording is ignored; reads work in any phase.
		drive_request(control_request(OP_RELEASE));
		drive_request(read_request(8'd0, 2'd0));
		drive_request(read_request(8'd2, 2'd2));
		drive_request(read_request(8'd1, 2'd1));

		setup = 0;
		while (requests_sent < REQUEST_TARGET) begin
			capture_round(setup);
			setup++;
		end
		in_valid = 1'b0;

		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending_results.size() == 0)
			$display("pretrigger_capture_buffer_core verification clean");
		else
			$display("pretrigger_capture_buffer_core verification failed");
		$finish;
	end

endmodule
